[rtl/march_memory_bist_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// March memory BIST sequencer assertion macros
// Clocked check helpers shared by the sequencer RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MARCH_MEMORY_BIST_SEQUENCER_CORE_ASSERT_SVH
`define MARCH_MEMORY_BIST_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define MBSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define MBSC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MBSC_ASSERT(lbl, prop, msg)
`define MBSC_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/mbsc_pkg.sv]
// ----------------------------------------------------------------------------
// March memory BIST sequencer package
// Test numbers, access codes and the per-test element decoder.
// ----------------------------------------------------------------------------
package mbsc_pkg;

	localparam int NUM_TESTS          = 19;
	localparam int REPEAT_COUNT_DEF   = 5;
	localparam int NUM_BITS           = 8;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [2:0] REG_BASE   = 3'd0;
	localparam logic [2:0] REG_LENGTH = 3'd1;
	localparam logic [2:0] REG_MASK   = 3'd2;
	localparam logic [2:0] REG_RANDOM = 3'd3;
	localparam logic [2:0] REG_WAIT   = 3'd4;

	localparam logic [3:0] RPT_TOTAL = 4'd8;

	localparam logic [4:0] T_RWRITE_A = 5'd0;
	localparam logic [4:0] T_RWRITE_B = 5'd1;
	localparam logic [4:0] T_RREAD_A  = 5'd2;
	localparam logic [4:0] T_RREAD_B  = 5'd3;
	localparam logic [4:0] T_CHECK    = 5'd4;
	localparam logic [4:0] T_CHECK_N  = 5'd5;
	localparam logic [4:0] T_WALK1    = 5'd6;
	localparam logic [4:0] T_WALK0    = 5'd7;
	localparam logic [4:0] T_MARCH_C  = 5'd8;
	localparam logic [4:0] T_MOVI_A   = 5'd9;
	localparam logic [4:0] T_MOVI_B   = 5'd10;
	localparam logic [4:0] T_MOVI_C   = 5'd11;
	localparam logic [4:0] T_MARCH_SS = 5'd12;
	localparam logic [4:0] T_MARCH_LA = 5'd13;
	localparam logic [4:0] T_RDEST_A  = 5'd14;
	localparam logic [4:0] T_RDEST_B  = 5'd15;
	localparam logic [4:0] T_AUNIQ_A  = 5'd16;
	localparam logic [4:0] T_AUNIQ_B  = 5'd17;
	localparam logic [4:0] T_RETAIN   = 5'd18;
	localparam logic [4:0] T_END      = 5'd19;

	// one march element: reads first, then writes, on one cell
	typedef struct packed {
		logic       ok;
		logic [7:0] nr;
		logic [7:0] nw;
		logic [7:0] rv;
		logic [7:0] wv;
		logic       wt;
		logic       stop;
	} elem_t;

	// decode test t, phase p at cell idx into its element
	function automatic elem_t describe(input logic [4:0] t, input logic [2:0] p,
			input logic [15:0] idx, input logic [2:0] walk, input logic [7:0] rnd,
			input logic [7:0] rep);
		elem_t      e;
		logic [7:0] v;
		logic [7:0] wb;
		e  = '0;
		v  = 8'h00;
		wb = 8'd1 << walk;
		unique case (t)
			T_RWRITE_A, T_RWRITE_B: begin
				e.ok = (p < 3'd2);
				if (p == 3'd0) begin
					e.nw = rep; e.wv = 8'h55;
				end else begin
					e.nr = 8'd1; e.rv = 8'h55;
				end
			end
			T_RREAD_A, T_RREAD_B: begin
				e.ok = (p < 3'd2);
				if (p == 3'd0) begin
					e.nw = 8'd1; e.wv = 8'h55;
				end else begin
					e.nr = rep; e.rv = 8'h55;
				end
			end
			T_CHECK, T_CHECK_N, T_WALK1, T_WALK0, T_AUNIQ_A, T_AUNIQ_B: begin
				if (t == T_CHECK || t == T_CHECK_N)
					v = ((idx[0] == 1'b0) == (t == T_CHECK)) ? 8'h55 : 8'hAA;
				else if (t == T_WALK1)
					v = wb;
				else if (t == T_WALK0)
					v = ~wb;
				else
					v = idx[7:0] ^ ((t == T_AUNIQ_A) ? 8'h55 : 8'hAA);
				e.ok = (p < 3'd2);
				if (p == 3'd0) begin
					e.nw = 8'd1; e.wv = v;
				end else begin
					e.nr = 8'd1; e.rv = v;
				end
			end
			T_MARCH_C, T_MARCH_LA: begin
				e.ok = (p < 3'd4);
				unique case (p)
					3'd0: begin e.nw = 8'd1; e.wv = 8'h00; end
					3'd1: begin e.nr = 8'd1; e.rv = 8'h00; e.nw = 8'd1; e.wv = 8'hFF; end
					3'd2: begin e.nr = 8'd1; e.rv = 8'hFF; e.nw = 8'd1; e.wv = 8'h00; end
					3'd3: begin e.nr = 8'd1; e.rv = 8'h00; end
					default: ;
				endcase
			end
			T_MOVI_A, T_MOVI_B, T_MOVI_C: begin
				v = (t == T_MOVI_A) ? 8'h00 : (t == T_MOVI_B) ? 8'h55 : rnd;
				e.ok = (p < 3'd4);
				unique case (p)
					3'd0: begin e.nw = 8'd1; e.wv = v; end
					3'd1: begin e.nr = 8'd1; e.rv = v; e.nw = 8'd1; e.wv = ~v; end
					3'd2: begin e.nr = 8'd1; e.rv = ~v; e.nw = 8'd1; e.wv = v; end
					3'd3: begin e.nr = 8'd1; e.rv = v; end
					default: ;
				endcase
			end
			T_MARCH_SS: begin
				e.ok = (p < 3'd6);
				unique case (p)
					3'd0: begin e.nw = 8'd1; e.wv = 8'h00; end
					3'd1, 3'd3: begin e.nr = 8'd1; e.rv = 8'h00; e.nw = 8'd1; e.wv = 8'hFF; end
					3'd2, 3'd4: begin e.nr = 8'd1; e.rv = 8'hFF; e.nw = 8'd1; e.wv = 8'h00; end
					3'd5: begin e.nr = 8'd1; e.rv = 8'h00; end
					default: ;
				endcase
			end
			T_RDEST_A, T_RDEST_B: begin
				v = (t == T_RDEST_A) ? 8'hAA : 8'h55;
				e.ok = (p < 3'd2);
				if (p == 3'd0) begin
					e.nw = 8'd1; e.wv = v;
				end else begin
					e.nr = rep; e.rv = v; e.stop = 1'b1;
				end
			end
			T_RETAIN: begin
				e.ok = (p < 3'd3);
				if (p == 3'd0) begin
					e.nw = 8'd1; e.wv = 8'hFF;
				end else if (p == 3'd1) begin
					e.wt = 1'b1;
				end else begin
					e.nr = 8'd1; e.rv = 8'hFF;
				end
			end
			default: ;
		endcase
		return e;
	endfunction

endpackage

[rtl/march_memory_bist_sequencer_core.sv]
// ----------------------------------------------------------------------------
// March memory BIST sequencer core
// Runs a nineteen-test memory self-test suite, at most one memory access per word.
// ----------------------------------------------------------------------------
// Each input word is one access slot: it carries the byte read in the previous
// slot and gets back the next access. A new word is accepted every clock while
// the output is not stalled; no word is accepted while the step engine crosses a
// pass or test boundary or skips a disabled test, as it moves one element at a
// time. The end of the suite returns nine report words, one per clock while
// m_tready is high, the last flagged by m_tlast.
`include "march_memory_bist_sequencer_core_assert.svh"
module march_memory_bist_sequencer_core
	import mbsc_pkg::*;
#(
	parameter int REPEAT_COUNT = REPEAT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] read_data
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] mem_op, [17:2] mem_address, [25:18] write_data, [26] busy_res,
	// [30:27] report_index, [62:31] report_count, [63] zero
	output logic [63:0] m_tdata,
	output logic [0:0]  m_tuser,   // [0] report_valid
	output logic        m_tlast
);

	localparam logic [7:0] REP = 8'(REPEAT_COUNT);

	// configuration registers
	logic [15:0] base_q, len_q;
	logic [18:0] mask_q;
	logic [7:0]  rnd_q;
	logic [31:0] wait_q;

	// input stage
	logic       in_valid_s1, first_s1, mode_s1;
	logic [7:0] rd_s1;

	// sequencer state
	logic [4:0]  test_q;
	logic [2:0]  phase_q;
	logic [15:0] offs_q;
	logic [31:0] inner_q;
	logic [2:0]  walk_q;
	logic [7:0]  exp_q;
	logic        pend_q, run_q;

	// output register
	logic        m_valid_q, rep_active_q, busy_q;
	logic [3:0]  rep_idx_q;
	logic [1:0]  op_q;
	logic [15:0] addr_q;
	logic [7:0]  wd_q;

	logic        cfg_wr, out_take, rep_more, out_free, go;
	logic        emit, finish, start, fail, cmp_en, stop_fail, cnt_clear;
	logic [7:0]  diff;
	logic [31:0] rpt_count;
	logic [15:0] off_e, idx;
	logic [31:0] inn_e;
	logic        down;
	elem_t       el;
	logic [8:0]  total;
	logic [4:0]  n_test;
	logic [2:0]  n_phase, n_walk;
	logic [15:0] n_offs;
	logic [31:0] n_inner;
	logic [7:0]  n_exp;
	logic        n_pend, n_run;
	logic [1:0]  r_op;
	logic [15:0] r_addr;
	logic [7:0]  r_wd;
	logic        r_busy;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 16'd0;
			len_q  <= 16'd16384;
			mask_q <= 19'h7FFFF;
			rnd_q  <= 8'd165;
			wait_q <= 32'd5000;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_BASE:   base_q <= pwdata[15:0];
				REG_LENGTH: len_q  <= pwdata[15:0];
				REG_MASK:   mask_q <= pwdata[18:0];
				REG_RANDOM: rnd_q  <= pwdata[7:0];
				REG_WAIT:   wait_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_BASE:   prdata = {16'd0, base_q};
			REG_LENGTH: prdata = {16'd0, len_q};
			REG_MASK:   prdata = {13'd0, mask_q};
			REG_RANDOM: prdata = {24'd0, rnd_q};
			REG_WAIT:   prdata = wait_q;
			default:    prdata = 32'd0;
		endcase
	end

	// output side flow control
	assign out_take = m_valid_q & m_tready;
	assign rep_more = rep_active_q & (rep_idx_q != RPT_TOTAL);
	assign out_free = !m_valid_q | (out_take & !rep_more);
	assign go       = in_valid_s1 & out_free;
	assign s_tready = !in_valid_s1 | (go & emit);

	// compare the read returned for the previous slot
	assign cmp_en    = go & first_s1 & mode_s1 & run_q & pend_q;
	assign diff      = rd_s1 ^ exp_q;
	assign fail      = cmp_en & (diff != 8'd0);
	assign stop_fail = fail & (test_q == T_RDEST_A || test_q == T_RDEST_B) & (phase_q == 3'd1);

	// a failing read-destructive compare moves to the next cell
	always_comb begin
		inn_e = inner_q;
		off_e = offs_q;
		if (stop_fail && inner_q != 32'd0) begin
			inn_e = 32'd0;
			off_e = offs_q + 16'd1;
		end
	end

	assign down = (test_q == T_MARCH_C || test_q == T_MARCH_SS || test_q == T_MARCH_LA) &&
		(phase_q == 3'd2 || phase_q == 3'd3);
	assign idx   = (down && off_e < len_q) ? (len_q - 16'd1 - off_e) : off_e;
	assign el    = describe(test_q, phase_q, idx, walk_q, rnd_q, REP);
	assign total = {1'b0, el.nr} + {1'b0, el.nw};

	// one step of the sequencer: start, issue an access, wait, end a pass, skip a test or finish
	always_comb begin
		n_test  = test_q;
		n_phase = phase_q;
		n_offs  = off_e;
		n_inner = inn_e;
		n_walk  = walk_q;
		n_exp   = exp_q;
		n_pend  = pend_q & !cmp_en;
		n_run   = run_q;
		emit    = 1'b0;
		finish  = 1'b0;
		start   = 1'b0;
		r_op    = OP_NONE;
		r_addr  = 16'd0;
		r_wd    = 8'd0;
		r_busy  = 1'b0;
		if (!mode_s1) begin
			start   = 1'b1;
			emit    = 1'b1;
			r_busy  = 1'b1;
			n_test  = 5'd0;
			n_phase = 3'd0;
			n_offs  = 16'd0;
			n_inner = 32'd0;
			n_walk  = 3'd0;
			n_exp   = 8'd0;
			n_pend  = 1'b0;
			n_run   = 1'b1;
		end else if (!run_q) begin
			emit = 1'b1;
		end else if (test_q >= T_END) begin
			emit   = 1'b1;
			finish = 1'b1;
			n_run  = 1'b0;
		end else if (!mask_q[test_q] || !el.ok) begin
			n_test  = test_q + 5'd1;
			n_phase = 3'd0;
			n_offs  = 16'd0;
			n_inner = 32'd0;
			n_walk  = 3'd0;
		end else if ((el.wt && inn_e >= wait_q) || (!el.wt && off_e >= len_q)) begin
			// end of pass; walking tests repeat per bit
			n_inner = 32'd0;
			n_offs  = 16'd0;
			if ((test_q == T_WALK1 || test_q == T_WALK0) && phase_q == 3'd1 &&
					walk_q != 3'd7) begin
				n_walk  = walk_q + 3'd1;
				n_phase = 3'd0;
			end else begin
				n_phase = phase_q + 3'd1;
			end
		end else if (el.wt) begin
			emit    = 1'b1;
			r_busy  = 1'b1;
			n_inner = inn_e + 32'd1;
		end else begin
			emit   = 1'b1;
			r_busy = 1'b1;
			r_addr = base_q + idx;
			if (inn_e < {24'd0, el.nr}) begin
				r_op   = OP_READ;
				n_exp  = el.rv;
				n_pend = el.stop | (inn_e == {24'd0, el.nr} - 32'd1);
			end else begin
				r_op = OP_WRITE;
				r_wd = el.wv;
			end
			if (inn_e + 32'd1 == {23'd0, total}) begin
				n_inner = 32'd0;
				n_offs  = off_e + 16'd1;
			end else begin
				n_inner = inn_e + 32'd1;
			end
		end
	end

	assign cnt_clear = go & start;

	mbsc_err_cnt u_err_cnt (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cnt_clear),
		.fail     (fail),
		.diff     (diff),
		.rd_idx   (rep_idx_q),
		.rd_count (rpt_count)
	);

	// hold the accepted slot word until its step emits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			first_s1    <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			in_valid_s1 <= 1'b1;
			first_s1    <= 1'b1;
		end else if (go) begin
			in_valid_s1 <= !emit;
			first_s1    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser[0];
			rd_s1   <= s_tdata;
		end
	end

	// advance sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			test_q  <= '0;
			phase_q <= '0;
			offs_q  <= '0;
			inner_q <= '0;
			walk_q  <= '0;
			exp_q   <= '0;
			pend_q  <= 1'b0;
			run_q   <= 1'b0;
		end else if (go) begin
			test_q  <= n_test;
			phase_q <= n_phase;
			offs_q  <= n_offs;
			inner_q <= n_inner;
			walk_q  <= n_walk;
			exp_q   <= n_exp;
			pend_q  <= n_pend;
			run_q   <= n_run;
		end
	end

	// output register and report word walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			rep_active_q <= 1'b0;
			rep_idx_q    <= '0;
		end else if (go && emit) begin
			m_valid_q    <= 1'b1;
			rep_active_q <= finish;
			rep_idx_q    <= '0;
		end else if (out_take && rep_more) begin
			rep_idx_q <= rep_idx_q + 4'd1;
		end else if (out_take) begin
			m_valid_q    <= 1'b0;
			rep_active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			op_q   <= r_op;
			addr_q <= r_addr;
			wd_q   <= r_wd;
			busy_q <= r_busy;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = rep_active_q;
	assign m_tlast  = rep_active_q & (rep_idx_q == RPT_TOTAL);
	assign m_tdata  = rep_active_q ?
		{1'b0, rpt_count, rep_idx_q, 1'b0, 8'd0, 16'd0, OP_NONE} :
		{1'b0, 32'd0, 4'd0, busy_q, wd_q, addr_q, op_q};

	`MBSC_ASSERT(a_start_runs, (go && mode_s1 == 1'b0) |=> run_q, "start did not begin suite")
	`MBSC_ASSERT(a_report_idle, (m_valid_q && rep_active_q) |-> !busy_q || !run_q, "report while running")
	`MBSC_NEVER(a_rep_range, rep_idx_q > RPT_TOTAL, "report index past total")
	`MBSC_NEVER(a_test_range, test_q > T_END, "test index past suite end")

endmodule

[rtl/mbsc_err_cnt.sv]
// ----------------------------------------------------------------------------
// Error counters
// Saturating per-bit and total miscompare counters with a report read port.
// ----------------------------------------------------------------------------
module mbsc_err_cnt
	import mbsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        fail,
	input  logic [7:0]  diff,
	input  logic [3:0]  rd_idx,
	output logic [31:0] rd_count
);

	logic [31:0] bit_cnt_q [NUM_BITS];
	logic [31:0] total_q;

	// count each failing compare and each differing bit, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int b = 0; b < NUM_BITS; b++)
				bit_cnt_q[b] <= '0;
		end else if (clear) begin
			total_q <= '0;
			for (int b = 0; b < NUM_BITS; b++)
				bit_cnt_q[b] <= '0;
		end else if (fail) begin
			if (total_q != 32'hFFFF_FFFF)
				total_q <= total_q + 32'd1;
			for (int b = 0; b < NUM_BITS; b++)
				if (diff[b] && bit_cnt_q[b] != 32'hFFFF_FFFF)
					bit_cnt_q[b] <= bit_cnt_q[b] + 32'd1;
		end
	end

	// select the word being reported
	always_comb begin
		if (rd_idx == RPT_TOTAL)
			rd_count = total_q;
		else
			rd_count = bit_cnt_q[rd_idx[2:0]];
	end

endmodule
